// File: rtl/core/bba_pkg.sv
// Shared types, widths and codes for the buddy block allocator.
// Used by the channel interfaces, the tree walk unit and the top level.
package bba_pkg;

	localparam int ADDR_W         = 20;
	localparam int COUNT_W        = 21;
	// Width for compares and shifts that may reach a whole pool of 2^32 bytes.
	localparam int WIDE_W         = 34;
	localparam int POOL_ORDER_DEF = 20;
	localparam int MIN_ORDER_DEF  = 12;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam logic MODE_ALLOC      = 1'b0;
	localparam logic MODE_FREE       = 1'b1;
	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_LOCATE,
		ST_SCAN,
		ST_SPLIT,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_DONE
	} bba_state_t;

endpackage

// File: rtl/core/bba_if.sv
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg for the payload types.
interface bba_req_if;
	import bba_pkg::*;

	logic   valid;
	logic   ready;
	logic   mode;
	addr_t  block_address;
	count_t byte_count;

	modport source (output valid, mode, block_address, byte_count, input ready);
	modport sink (input valid, mode, block_address, byte_count, output ready);
endinterface

interface bba_rsp_if;
	import bba_pkg::*;

	logic  valid;
	logic  ready;
	logic  status;
	addr_t granted_address;

	modport source (output valid, status, granted_address, input ready);
	modport sink (input valid, status, granted_address, output ready);
endinterface

// File: rtl/core/bba_walk.sv
// Tree walk unit: heap position, pre-order successor and byte offset of one tree node.
// Depends on bba_pkg; instantiated by buddy_block_allocator.
module bba_walk #(
	parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
	parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF,
	localparam int LEVELS    = POOL_ORDER - MIN_ORDER + 1,
	localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1,
	localparam int IW        = (LEVELS > 1) ? LEVELS - 1 : 1
) (
	input  logic [LW-1:0]      lvl,
	input  logic [IW-1:0]      idx,
	input  logic [LW-1:0]      lim,
	output logic [LEVELS-1:0]  heap,
	output logic [LW-1:0]      nxt_lvl,
	output logic [IW-1:0]      nxt_idx,
	output logic               nxt_end,
	output bba_pkg::addr_t     offset
);
	import bba_pkg::*;

	logic [IW:0]   succ;
	logic [LW-1:0] tz;
	logic          descend;
	logic          last;

	// Heap numbering: root is 1, children of h are 2h and 2h+1.
	assign heap = (LEVELS'(1) << lvl) | LEVELS'(idx);

	assign offset = ADDR_W'((WIDE_W'(idx) << (LW'(LEVELS - 1) - lvl)) << MIN_ORDER);

	// Pre-order successor limited to depth lim: go to the left child while allowed,
	// otherwise climb out of every subtree in which this node was the right child.
	always_comb begin
		succ    = (IW+1)'(idx) + (IW+1)'(1);
		last    = (succ == ((IW+1)'(1) << lvl));
		descend = (lvl < lim);
		tz      = '0;
		for (int k = IW; k >= 0; k--) begin
			if (succ[k]) begin
				tz = LW'(k);
			end
		end
		if (descend) begin
			nxt_lvl = lvl + LW'(1);
			nxt_idx = IW'(idx << 1);
		end else begin
			nxt_lvl = lvl - tz;
			nxt_idx = IW'(succ >> tz);
		end
		nxt_end = !descend && last;
	end

endmodule

// File: rtl/core/buddy_block_allocator.sv
// Buddy block allocator: top level with the sequencer and the free-mark memory.
// Depends on bba_pkg, bba_req_if, bba_rsp_if and bba_walk.
//
// Use: items arrive on req (mode, block_address, byte_count) and each produces one
// item on rsp (status, granted_address). Both channels move an item when valid and
// ready are high at a rising clock edge. One request is worked on at a time.
// An allocate scans the free-mark tree in pre-order, one node per cycle through the
// registered memory read, then writes one split per cycle.
// A free climbs the tree one level per merge with a free buddy, at most to the whole pool.
// The memory has one write and one read port.
// After reset the block runs a clearing pass over every memory row that leaves only
// the whole pool free; req.ready stays low until it ends.
// The result waits in an output register. While it is not taken, the next request is
// still accepted and worked on, and it waits at its end until the register is free.
module buddy_block_allocator #(
	parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
	parameter int MIN_ORDER  = bba_pkg::MIN_ORDER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	import bba_pkg::*;

	localparam int LEVELS = POOL_ORDER - MIN_ORDER + 1;
	localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int IW     = (LEVELS > 1) ? LEVELS - 1 : 1;
	localparam int RAW    = IW;
	localparam int ROWS   = 1 << RAW;

	bba_state_t state_q, state_d;

	logic              mode_q;
	count_t            count_q;
	logic [IW-1:0]     pos_q;
	logic [LW-1:0]     lim_q, lim_d;
	logic              fail_q, fail_d;
	logic [LW-1:0]     lvl_q, lvl_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic              scan_end_q, scan_end_d;
	logic              rd_vld_s1, rd_vld_d;
	logic [LW-1:0]     lvl_s1;
	logic [IW-1:0]     idx_s1;
	logic [RAW-1:0]    row_s1;
	logic              bit_s1;
	logic [RAW-1:0]    clr_row_q;
	logic              out_vld_q;
	logic              res_status_q;
	addr_t             res_addr_q;
	logic              load_out;

	// Each row holds the marks of a sibling pair; row 0 holds the root in bit 1.
	logic [1:0]        mark_mem [ROWS];
	logic [1:0]        mark_rd_q;
	logic              mem_we, mem_re;
	logic [RAW-1:0]    mem_wrow, mem_rrow;
	logic [1:0]        mem_wmask, mem_wdata;

	logic [LEVELS-1:0] fit;
	logic [LW-1:0]     lim_calc;
	logic [LEVELS-1:0] w_heap;
	logic [LW-1:0]     w_nxt_lvl;
	logic [IW-1:0]     w_nxt_idx;
	logic              w_nxt_end;
	addr_t             w_offset;
	logic [RAW-1:0]    cur_row;
	logic              cur_bit;

	bba_walk #(
		.POOL_ORDER (POOL_ORDER),
		.MIN_ORDER  (MIN_ORDER)
	) u_walk (
		.lvl     (lvl_q),
		.idx     (idx_q),
		.lim     (lim_q),
		.heap    (w_heap),
		.nxt_lvl (w_nxt_lvl),
		.nxt_idx (w_nxt_idx),
		.nxt_end (w_nxt_end),
		.offset  (w_offset)
	);

	assign cur_row = RAW'(w_heap >> 1);
	assign cur_bit = w_heap[0];

	// Deepest level whose block size still holds the byte count; fit[0] clear means
	// not even the whole pool is large enough.
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			fit[l] = (WIDE_W'(count_q) <= (WIDE_W'(1) << (POOL_ORDER - l)));
		end
		lim_calc = fit[0] ? LW'($countones(fit) - 1) : '0;
	end

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.status          = res_status_q;
	assign rsp.granted_address = res_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		lim_d      = lim_q;
		fail_d     = fail_q;
		lvl_d      = lvl_q;
		idx_d      = idx_q;
		scan_end_d = scan_end_q;
		rd_vld_d   = 1'b0;
		load_out   = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_wrow   = cur_row;
		mem_rrow   = cur_row;
		mem_wmask  = 2'b00;
		mem_wdata  = 2'b00;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wrow  = clr_row_q;
				mem_wmask = 2'b11;
				mem_wdata = (clr_row_q == '0) ? 2'b10 : 2'b00;
				if (clr_row_q == RAW'(ROWS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				lim_d  = lim_calc;
				fail_d = (mode_q == MODE_ALLOC) && !fit[0];
				if (mode_q == MODE_FREE) begin
					state_d = ST_LOCATE;
				end else if (!fit[0]) begin
					state_d = ST_DONE;
				end else begin
					lvl_d      = '0;
					idx_d      = '0;
					scan_end_d = 1'b0;
					state_d    = ST_SCAN;
				end
			end
			ST_LOCATE: begin
				lvl_d   = lim_q;
				idx_d   = IW'(pos_q >> (IW - int'(lim_q)));
				state_d = ST_FREE_RD;
			end
			ST_SCAN: begin
				// The node read last cycle is checked while the next one is fetched.
				if (rd_vld_s1 && mark_rd_q[bit_s1]) begin
					mem_we    = 1'b1;
					mem_wrow  = row_s1;
					mem_wmask = bit_s1 ? 2'b10 : 2'b01;
					lvl_d     = lvl_s1;
					idx_d     = idx_s1;
					state_d   = ST_SPLIT;
				end else if (scan_end_q) begin
					if (!rd_vld_s1) begin
						fail_d  = 1'b1;
						state_d = ST_DONE;
					end
				end else begin
					mem_re     = 1'b1;
					rd_vld_d   = 1'b1;
					lvl_d      = w_nxt_lvl;
					idx_d      = w_nxt_idx;
					scan_end_d = w_nxt_end;
				end
			end
			ST_SPLIT: begin
				// The row of a node's children is the node's own heap number.
				if (lvl_q < lim_q) begin
					mem_we    = 1'b1;
					mem_wrow  = RAW'(w_heap);
					mem_wmask = 2'b10;
					mem_wdata = 2'b10;
					lvl_d     = lvl_q + LW'(1);
					idx_d     = IW'(idx_q << 1);
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FREE_RD: begin
				if (lvl_q == '0) begin
					mem_we    = 1'b1;
					mem_wmask = cur_bit ? 2'b10 : 2'b01;
					mem_wdata = 2'b11;
					state_d   = ST_DONE;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_FREE_CHK;
				end
			end
			ST_FREE_CHK: begin
				// The freed node is written only once merging stops; a merge clears
				// both halves, whatever the node's own mark was.
				mem_we = 1'b1;
				if (mark_rd_q[~cur_bit]) begin
					mem_wmask = 2'b11;
					mem_wdata = 2'b00;
					lvl_d     = lvl_q - LW'(1);
					idx_d     = idx_q >> 1;
					state_d   = ST_FREE_RD;
				end else begin
					mem_wmask = cur_bit ? 2'b10 : 2'b01;
					mem_wdata = 2'b11;
					state_d   = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_vld_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q  <= '0;
			rd_vld_s1  <= 1'b0;
			scan_end_q <= 1'b0;
			fail_q     <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_row_q <= clr_row_q + RAW'(1);
			end
			rd_vld_s1  <= rd_vld_d;
			scan_end_q <= scan_end_d;
			fail_q     <= fail_d;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q  <= req.mode;
			count_q <= req.byte_count;
			pos_q   <= IW'(WIDE_W'(req.block_address) >> MIN_ORDER);
		end
		lim_q <= lim_d;
		lvl_q <= lvl_d;
		idx_q <= idx_d;
		if (rd_vld_d) begin
			lvl_s1 <= lvl_q;
			idx_s1 <= idx_q;
			row_s1 <= cur_row;
			bit_s1 <= cur_bit;
		end
		if (load_out) begin
			res_status_q <= fail_q ? STATUS_NO_SPACE : STATUS_DONE;
			res_addr_q   <= ((mode_q == MODE_ALLOC) && !fail_q) ? w_offset : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			if (mem_wmask[0]) begin
				mark_mem[mem_wrow][0] <= mem_wdata[0];
			end
			if (mem_wmask[1]) begin
				mark_mem[mem_wrow][1] <= mem_wdata[1];
			end
		end
		if (mem_re) begin
			mark_rd_q <= mark_mem[mem_rrow];
		end
	end

`ifndef NO_ASSERTIONS
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_wrow != mem_rrow))
		else $error("free-mark memory read and written at the same row");

	a_split_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SPLIT) |-> (lvl_q <= lim_q))
		else $error("split went below the level that fits the request");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && res_status_q == STATUS_NO_SPACE) |-> (res_addr_q == '0))
		else $error("failed allocate reports a non-zero address");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_vld_q || rsp.ready)) |=> (out_vld_q && state_q == ST_IDLE))
		else $error("finished item not placed in the output register");
`endif

endmodule

// File: tb/sv/buddy_block_allocator_tb.sv
// Self-checking testbench for the buddy block allocator: a directed table, then random requests.
// Depends on bba_pkg, the bba_req_if and bba_rsp_if channels and the buddy_block_allocator top.
`timescale 1ns / 1ps

module buddy_block_allocator_tb;
	import bba_pkg::*;

	localparam int POOL_ORDER   = POOL_ORDER_DEF;
	localparam int MIN_ORDER    = MIN_ORDER_DEF;
	localparam int LEVELS       = POOL_ORDER - MIN_ORDER + 1;
	localparam int NODES        = (1 << LEVELS) - 1;
	localparam int RANDOM_ITEMS = 1075;
	localparam int HOLD_CYCLES  = 700;
	localparam int DRAIN_CYCLES = (1 << LEVELS) + 40;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int DIRECTED_ROWS = 25;

	localparam logic ROW_PINNED    = 1'b1;
	localparam logic ROW_PREDICTED = 1'b0;

	typedef struct packed {
		logic   mode;
		addr_t  block_address;
		count_t byte_count;
	} request_t;

	typedef struct packed {
		logic  status;
		addr_t granted_address;
	} grant_t;

	typedef struct packed {
		logic   mode;
		addr_t  block_address;
		count_t byte_count;
		logic   pinned;
		logic   status;
		addr_t  granted_address;
	} dir_row_t;

	typedef struct {
		addr_t  addr;
		count_t count;
	} held_t;

	logic clk;
	logic arst_n;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	buddy_block_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Rows whose result can be read straight off the behaviour carry it; the rest are predicted.
	dir_row_t directed_tab [DIRECTED_ROWS] = '{
		'{MODE_ALLOC, 20'h00000, 21'd2097151, ROW_PINNED,    STATUS_NO_SPACE, 20'h00000},
		'{MODE_ALLOC, 20'hFFFFF, 21'd1048577, ROW_PINNED,    STATUS_NO_SPACE, 20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd1048576, ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd1,       ROW_PINNED,    STATUS_NO_SPACE, 20'h00000},
		'{MODE_FREE,  20'h00000, 21'd1048576, ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'hFFFFF, 21'd0,       ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd4096,    ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd4097,    ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'hFFFFF, 21'd4096,    ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h00000, 21'd0,       ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h01000, 21'd4095,    ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h02000, 21'd8192,    ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h00000, 21'd1048576, ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h55555, 21'd2048,    ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h00000, 21'd2097151, ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'hAAAAA, 21'd4096,    ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd524288,  ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd524289,  ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h80000, 21'd524288,  ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h00000, 21'd1048576, ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd1048576, ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h12345, 21'd65537,   ROW_PINNED,    STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd65536,   ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_ALLOC, 20'h00000, 21'd1,       ROW_PREDICTED, STATUS_DONE,     20'h00000},
		'{MODE_FREE,  20'h00000, 21'd1048576, ROW_PINNED,    STATUS_DONE,     20'h00000}
	};

	bit       free_map [NODES];
	grant_t   pending_grants [$];
	held_t    held_blocks [$];
	int       fail_count = 0;
	int       n_granted;
	int       n_refused;
	int       n_freed;
	int       n_holds = 0;
	logic     hold_request;

	function automatic int unsigned node_of(int unsigned level, longint unsigned idx);
		return (32'd1 << level) - 32'd1 + int'(idx);
	endfunction

	function automatic grant_t grant_block(count_t count);
		bit              found;
		int unsigned     lvl;
		int unsigned     best_level;
		longint unsigned best_idx;
		longint unsigned best_off;
		longint unsigned i;
		longint unsigned off;
		grant_t          res;
		found = 1'b0;
		best_level = 0;
		best_idx = 0;
		best_off = 0;
		for (lvl = 0; lvl < LEVELS; lvl++) begin
			if ((64'd1 << (POOL_ORDER - lvl)) < count)
				break;
			for (i = 0; i < (64'd1 << lvl); i++) begin
				off = i << (POOL_ORDER - lvl);
				// Strictly lower offset only, so a larger block at the same offset wins.
				if (free_map[node_of(lvl, i)] && (!found || off < best_off)) begin
					found = 1'b1;
					best_level = lvl;
					best_idx = i;
					best_off = off;
				end
			end
		end
		if (!found) begin
			res.status = STATUS_NO_SPACE;
			res.granted_address = '0;
			return res;
		end
		free_map[node_of(best_level, best_idx)] = 1'b0;
		while (best_level + 1 < LEVELS) begin
			if (count > (64'd1 << (POOL_ORDER - best_level - 1)))
				break;
			best_level++;
			best_idx = best_idx << 1;
			free_map[node_of(best_level, best_idx + 1)] = 1'b1;
		end
		res.status = STATUS_DONE;
		res.granted_address = addr_t'(best_idx << (POOL_ORDER - best_level));
		return res;
	endfunction

	function automatic void release_block(addr_t addr, count_t count);
		int unsigned     order;
		int unsigned     lvl;
		longint unsigned i;
		order = MIN_ORDER;
		while (order < POOL_ORDER && (64'd1 << order) < count)
			order++;
		lvl = POOL_ORDER - order;
		i = longint'(addr) >> order;
		free_map[node_of(lvl, i)] = 1'b1;
		while (lvl > 0) begin
			if (!free_map[node_of(lvl, i ^ 1)])
				break;
			free_map[node_of(lvl, i)] = 1'b0;
			free_map[node_of(lvl, i ^ 1)] = 1'b0;
			i = i >> 1;
			lvl--;
			free_map[node_of(lvl, i)] = 1'b1;
		end
	endfunction

	// Offers one item after a random gap, waits for it to be taken and records what it must return.
	task automatic offer_item(input request_t item, input logic pinned, input grant_t pinned_res,
			output grant_t res);
		int unsigned r;
		int unsigned gap;
		r = $urandom_range(0, 99);
		if (r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= item.mode;
		req_ch.block_address <= item.block_address;
		req_ch.byte_count    <= item.byte_count;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (item.mode == MODE_ALLOC) begin
			res = grant_block(item.byte_count);
			if (res.status == STATUS_DONE)
				n_granted++;
			else
				n_refused++;
		end else begin
			release_block(item.block_address, item.byte_count);
			res.status = STATUS_DONE;
			res.granted_address = '0;
			n_freed++;
		end
		pending_grants.push_back(pinned ? pinned_res : res);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timed out with %0d results outstanding.", pending_grants.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Response side: takes results with runs of ready, short and long stalls, and one long hold.
	initial begin
		logic        seg_ready;
		int unsigned seg_left;
		int unsigned r;
		grant_t      want;
		bit          hold_taken;
		seg_ready = 1'b0;
		seg_left = 0;
		hold_taken = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_grants.size() == 0) begin
					$error("result with nothing expected: status %0d granted_address 0x%05h",
						rsp_ch.status, rsp_ch.granted_address);
					fail_count++;
				end else begin
					want = pending_grants.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.granted_address !== want.granted_address) begin
						$error("granted_address: expected 0x%05h, got 0x%05h",
							want.granted_address, rsp_ch.granted_address);
						fail_count++;
					end
				end
			end
			if (seg_left == 0) begin
				if (hold_request && !hold_taken) begin
					hold_taken = 1'b1;
					seg_ready = 1'b0;
					seg_left = HOLD_CYCLES;
					n_holds++;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 65) begin
						seg_ready = 1'b1;
						seg_left = $urandom_range(1, 30);
					end else if (r < 95) begin
						seg_ready = 1'b0;
						seg_left = $urandom_range(1, 4);
					end else begin
						seg_ready = 1'b0;
						seg_left = $urandom_range(20, 60);
					end
				end
			end
			rsp_ch.ready <= seg_ready;
			seg_left--;
		end
	end

	initial begin
		request_t    item;
		grant_t      res;
		grant_t      fixed_res;
		held_t       blk;
		int unsigned r;
		int unsigned idx;
		n_granted = 0;
		n_refused = 0;
		n_freed = 0;
		hold_request = 1'b0;
		foreach (free_map[k])
			free_map[k] = 1'b0;
		free_map[0] = 1'b1;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.mode          <= MODE_ALLOC;
		req_ch.block_address <= '0;
		req_ch.byte_count    <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tab[n]) begin
			item.mode          = directed_tab[n].mode;
			item.block_address = directed_tab[n].block_address;
			item.byte_count    = directed_tab[n].byte_count;
			fixed_res.status          = directed_tab[n].status;
			fixed_res.granted_address = directed_tab[n].granted_address;
			offer_item(item, directed_tab[n].pinned, fixed_res, res);
		end

		// Mostly allocations paired with frees of blocks actually held, plus a little noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				hold_request <= 1'b1;
			r = $urandom_range(0, 99);
			item.block_address = addr_t'($urandom);
			if (r < 4) begin
				item.mode = MODE_FREE;
				if ($urandom_range(0, 3) == 0)
					item.byte_count = count_t'($urandom);
				else
					item.byte_count = count_t'($urandom_range(0, 16384));
			end else if (r < 7) begin
				item.mode = MODE_ALLOC;
				item.byte_count = count_t'($urandom);
			end else if (held_blocks.size() > 0 && (r < 45 || held_blocks.size() > 40)) begin
				idx = $urandom_range(0, held_blocks.size() - 1);
				blk = held_blocks[idx];
				held_blocks.delete(idx);
				item.mode = MODE_FREE;
				item.block_address = blk.addr;
				item.byte_count = blk.count;
			end else begin
				item.mode = MODE_ALLOC;
				r = $urandom_range(0, 99);
				if (r < 55)
					item.byte_count = count_t'($urandom_range(0, 8192));
				else if (r < 85)
					item.byte_count = count_t'($urandom_range(0, 65536));
				else if (r < 97)
					item.byte_count = count_t'($urandom_range(0, 1 << POOL_ORDER));
				else
					item.byte_count = count_t'($urandom_range(0, (1 << COUNT_W) - 1));
			end
			offer_item(item, ROW_PREDICTED, '0, res);
			if (item.mode == MODE_ALLOC && res.status == STATUS_DONE) begin
				blk.addr = res.granted_address;
				blk.count = item.byte_count;
				held_blocks.push_back(blk);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_grants.size() != 0)
			$error("%0d expected results never arrived", pending_grants.size());

		$display("Sent %0d requests: %0d grants, %0d refusals, %0d frees.",
			DIRECTED_ROWS + RANDOM_ITEMS, n_granted, n_refused, n_freed);
		$display("Response side held off %0d time(s) for %0d cycles; %0d mismatches.",
			n_holds, HOLD_CYCLES, fail_count);
		if (fail_count == 0 && pending_grants.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
